// ----- sv/ngga_pkg.sv -----
// Shared constants, types and the header lookup for the GGA position extractor.
package ngga_pkg;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [2:0] HDR_LEN    = 3'd6;
    localparam logic [2:0] HDR_DONE   = 3'd7;
    localparam logic [2:0] NUM_FIELDS = 3'd5;

    // Field ids; they also equal the field position after the header.
    localparam logic [2:0] FID_TIME = 3'd0;
    localparam logic [2:0] FID_LAT  = 3'd1;
    localparam logic [2:0] FID_NS   = 3'd2;
    localparam logic [2:0] FID_LON  = 3'd3;
    localparam logic [2:0] FID_EW   = 3'd4;

    typedef struct packed {
        logic take;       // input request accepted this cycle
        logic run_start;  // qualifying newline: point at first result
        logic rd;         // read the pointed character into the output register
        logic advance;    // output request taken: move the pointer
    } t_cmd;

    typedef struct packed {
        logic nl_ok;      // input byte is a newline that ends a good line
        logic last;       // pointer sits on the final result of the run
    } t_sts;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "$";
            3'd1:    c = "G";
            3'd2:    c = "P";
            3'd3:    c = "G";
            3'd4:    c = "G";
            default: c = "A";
        endcase
        return c;
    endfunction

endpackage

// ----- sv/ngga_ctrl.sv -----
// Controller FSM: input acceptance and result run sequencing.
module ngga_ctrl
    import ngga_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall,
    output logic o_out_valid
);

    localparam logic [1:0] S_IN  = 2'd0;
    localparam logic [1:0] S_RD  = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IN: begin
                o_cmd.take = i_valid;
                if (i_valid && i_sts.nl_ok) begin
                    o_cmd.run_start = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    o_cmd.advance = 1'b1;
                    n_state       = i_sts.last ? S_IN : S_RD;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IN);
    assign o_out_valid = (r_state == S_OUT);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stall) |=> (r_state == S_OUT))
        else $error("result dropped while receiver stalled");

    a_read_then_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_OUT))
        else $error("read cycle not followed by result");

endmodule

// ----- sv/ngga_dp.sv -----
// Datapath: line parser state, field buffers and result pointer.
module ngga_dp
    import ngga_pkg::*;
#(
    parameter int FIELD_CHARS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rx_byte,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic [2:0] o_field_id,
    output logic [3:0] o_char_index,
    output logic [7:0] o_char_byte,
    output logic       o_last_of_run
);

    localparam int IW = $clog2(FIELD_CHARS);
    localparam int CW = $clog2(FIELD_CHARS + 1);

    logic [2:0]    r_hp, n_hp;
    logic [2:0]    r_fc, n_fc;
    logic [CW-1:0] r_cif, n_cif;
    logic          r_rej, n_rej;
    logic [CW-1:0] r_len [3];
    logic [CW-1:0] n_len [3];
    logic          wr_en;

    logic [7:0] r_time_mem [FIELD_CHARS];
    logic [7:0] r_lat_mem  [FIELD_CHARS];
    logic [7:0] r_lon_mem  [FIELD_CHARS];
    logic [7:0] r_hemi_ns, r_hemi_ew;
    logic [7:0] r_rd;

    logic [2:0]    r_sel, n_sel;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] idx_inc;

    logic is_nl, is_comma;

    assign is_nl    = (i_rx_byte == CH_NL);
    assign is_comma = (i_rx_byte == CH_COMMA);

    // Line parser next state
    always_comb begin
        n_hp  = r_hp;
        n_fc  = r_fc;
        n_cif = r_cif;
        n_rej = r_rej;
        n_len = r_len;
        wr_en = 1'b0;
        if (i_cmd.take) begin
            if (is_nl) begin
                n_hp  = 3'd0;
                n_fc  = 3'd0;
                n_cif = '0;
                n_rej = 1'b0;
            end else if (!r_rej) begin
                if (r_hp != HDR_DONE) begin
                    if (is_comma) begin
                        if (r_hp == HDR_LEN) n_hp = HDR_DONE;
                        else                 n_rej = 1'b1;
                    end else if (r_hp != HDR_LEN && i_rx_byte == hdr_char(r_hp)) begin
                        n_hp = r_hp + 3'd1;
                    end else begin
                        n_rej = 1'b1;
                    end
                end else if (r_fc != NUM_FIELDS) begin
                    if (is_comma) begin
                        if (r_cif == '0) begin
                            n_rej = 1'b1;
                        end else begin
                            case (r_fc)
                                FID_TIME: n_len[0] = r_cif;
                                FID_LAT:  n_len[1] = r_cif;
                                FID_LON:  n_len[2] = r_cif;
                                default:  ;
                            endcase
                            n_fc  = r_fc + 3'd1;
                            n_cif = '0;
                        end
                    end else if (r_cif >= CW'(FIELD_CHARS)) begin
                        n_rej = 1'b1;
                    end else begin
                        wr_en = 1'b1;
                        n_cif = r_cif + CW'(1);
                    end
                end
            end
        end
    end

    assign o_sts.nl_ok = is_nl && !r_rej && (r_hp == HDR_DONE) &&
                         ((r_fc == NUM_FIELDS) ||
                          (r_fc == NUM_FIELDS - 3'd1 && r_cif != '0));
    assign o_sts.last  = (r_sel == FID_EW);

    // Result pointer: walks time, lat, N/S, lon, E/W
    assign idx_inc = CW'(r_idx) + CW'(1);

    always_comb begin
        n_sel = r_sel;
        n_idx = r_idx;
        if (i_cmd.run_start) begin
            n_sel = FID_TIME;
            n_idx = '0;
        end else if (i_cmd.advance) begin
            case (r_sel)
                FID_TIME: begin
                    if (idx_inc == r_len[0]) begin
                        n_sel = FID_LAT;
                        n_idx = '0;
                    end else begin
                        n_idx = idx_inc[IW-1:0];
                    end
                end
                FID_LAT: begin
                    if (idx_inc == r_len[1]) begin
                        n_sel = FID_NS;
                        n_idx = '0;
                    end else begin
                        n_idx = idx_inc[IW-1:0];
                    end
                end
                FID_NS: begin
                    n_sel = FID_LON;
                    n_idx = '0;
                end
                FID_LON: begin
                    if (idx_inc == r_len[2]) begin
                        n_sel = FID_EW;
                        n_idx = '0;
                    end else begin
                        n_idx = idx_inc[IW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp  <= 3'd0;
            r_fc  <= 3'd0;
            r_cif <= '0;
            r_rej <= 1'b0;
            r_len <= '{default: '0};
            r_sel <= FID_TIME;
            r_idx <= '0;
        end else begin
            r_hp  <= n_hp;
            r_fc  <= n_fc;
            r_cif <= n_cif;
            r_rej <= n_rej;
            r_len <= n_len;
            r_sel <= n_sel;
            r_idx <= n_idx;
        end
    end

    // Field buffers; write side at parse time, registered read at run time
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (r_fc)
                FID_TIME: r_time_mem[r_cif[IW-1:0]] <= i_rx_byte;
                FID_LAT:  r_lat_mem[r_cif[IW-1:0]]  <= i_rx_byte;
                FID_NS:   if (r_cif == '0) r_hemi_ns <= i_rx_byte;
                FID_LON:  r_lon_mem[r_cif[IW-1:0]]  <= i_rx_byte;
                default:  if (r_cif == '0) r_hemi_ew <= i_rx_byte;
            endcase
        end
        if (i_cmd.rd) begin
            case (r_sel)
                FID_TIME: r_rd <= r_time_mem[r_idx];
                FID_LAT:  r_rd <= r_lat_mem[r_idx];
                FID_NS:   r_rd <= r_hemi_ns;
                FID_LON:  r_rd <= r_lon_mem[r_idx];
                default:  r_rd <= r_hemi_ew;
            endcase
        end
    end

    assign o_field_id    = r_sel;
    assign o_char_index  = 4'(r_idx);
    assign o_char_byte   = r_rd;
    assign o_last_of_run = (r_sel == FID_EW);

    a_time_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd && r_sel == FID_TIME) |-> (CW'(r_idx) < r_len[0]))
        else $error("time read past stored length");

    a_cif_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cif <= CW'(FIELD_CHARS))
        else $error("field character count overran buffer");

    a_ns_to_lon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.advance && r_sel == FID_NS) |=> (r_sel == FID_LON && r_idx == '0))
        else $error("pointer did not move from N/S to longitude start");

endmodule

// ----- sv/nmea_gga_position_extractor.sv -----
// GGA sentence position extractor: top level.
// Input channel: one received byte per request on i_rx_byte (i_valid / o_stall).
// Ordinary bytes are taken one per cycle; o_stall stays low between lines.
// A newline that ends a good $GPGGA line (five non-empty fields, each at most
// FIELD_CHARS characters) starts a run of results on the output channel
// (o_valid / i_stall): time, latitude, N/S, longitude, E/W characters, each
// with field id and index, o_last_of_run set on the E/W character.
// Other lines produce no output.
// During a run o_stall is high; each result is a buffer read (S_RD), then
// the output register (S_OUT), and any receiver stall lengthens the run.
// The first result follows the taken newline through S_RD and S_OUT in turn.
// While i_stall is high the result holds in its register.
// Reset (synchronous, active low) returns to start of line and drops any
// run in progress; field buffers need no clearing.
module nmea_gga_position_extractor
    import ngga_pkg::*;
#(
    parameter int FIELD_CHARS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_field_id,
    output logic [3:0] o_char_index,
    output logic [7:0] o_char_byte,
    output logic       o_last_of_run
);

    t_cmd cmd;
    t_sts sts;

    ngga_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    ngga_dp #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_field_id    (o_field_id),
        .o_char_index  (o_char_index),
        .o_char_byte   (o_char_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule
